// File: sv/reed_solomon_ecc_encoder_top_assert.svh
// Assertion macros used by the checker file of the encoder.
`ifndef REED_SOLOMON_ECC_ENCODER_TOP_ASSERT_SVH
`define REED_SOLOMON_ECC_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rse_pkg.sv
`timescale 1ns / 1ps

package rse_pkg;

	// Parity word count selections.
	localparam logic [1:0] MODE_P10 = 2'd0;
	localparam logic [1:0] MODE_P16 = 2'd1;
	localparam logic [1:0] MODE_P26 = 2'd2;

	// Field reduction polynomial 0x11D without its x^8 term.
	localparam logic [7:0] GF_POLY = 8'h1D;

	// Generator polynomial exponents of alpha, leading term first.
	localparam logic [7:0] GEN10_EXP [11] = '{
		8'd0, 8'd251, 8'd67, 8'd46, 8'd61, 8'd118, 8'd70, 8'd64, 8'd94, 8'd32, 8'd45
	};
	localparam logic [7:0] GEN16_EXP [17] = '{
		8'd0, 8'd120, 8'd104, 8'd107, 8'd109, 8'd102, 8'd161, 8'd76, 8'd3,
		8'd91, 8'd191, 8'd147, 8'd169, 8'd182, 8'd194, 8'd225, 8'd120
	};
	localparam logic [7:0] GEN26_EXP [27] = '{
		8'd0, 8'd173, 8'd125, 8'd158, 8'd2, 8'd103, 8'd182, 8'd118, 8'd17,
		8'd145, 8'd201, 8'd111, 8'd28, 8'd165, 8'd53, 8'd161, 8'd21, 8'd245,
		8'd142, 8'd13, 8'd102, 8'd48, 8'd227, 8'd153, 8'd145, 8'd218, 8'd70
	};

	// Handoff from the division stage to the parity shifter.
	typedef struct packed {
		logic       load;
		logic [1:0] mode;
	} rse_load_t;

	// Multiply by alpha in GF(256).
	function automatic logic [7:0] gf_xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	// General GF(256) multiply; with a constant b it reduces to an XOR network.
	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

	// alpha^e, evaluated only on constants at elaboration.
	function automatic logic [7:0] gf_alpha(int e);
		logic [7:0] v;
		v = 8'h01;
		for (int k = 0; k < e % 255; k++) begin
			v = gf_xtime(v);
		end
		return v;
	endfunction

	// Generator coefficient idx for a mode; zero past the generator's degree.
	function automatic logic [7:0] rse_coef(logic [1:0] mode, int idx);
		logic [7:0] c;
		c = 8'h00;
		case (mode)
			MODE_P10: begin
				if (idx <= 10) c = gf_alpha(int'(GEN10_EXP[idx]));
			end
			MODE_P16: begin
				if (idx <= 16) c = gf_alpha(int'(GEN16_EXP[idx]));
			end
			default: begin
				if (idx <= 26) c = gf_alpha(int'(GEN26_EXP[idx]));
			end
		endcase
		return c;
	endfunction

	// Nominal parity word count of a mode; the unused code acts as 26.
	function automatic logic [4:0] rse_count(logic [1:0] mode);
		logic [4:0] n;
		case (mode)
			MODE_P10: n = 5'd10;
			MODE_P16: n = 5'd16;
			default:  n = 5'd26;
		endcase
		return n;
	endfunction

endpackage

// File: sv/rse_in_if.sv
`timescale 1ns / 1ps

// Data byte channel.
interface rse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_data;

	modport source (output valid, output data_byte, output last_data, input ready);
	modport sink (input valid, input data_byte, input last_data, output ready);
endinterface

// File: sv/rse_out_if.sv
`timescale 1ns / 1ps

// Parity byte channel.
interface rse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ecc_byte;
	logic       last_ecc;

	modport source (output valid, output ecc_byte, output last_ecc, input ready);
	modport sink (input valid, input ecc_byte, input last_ecc, output ready);
endinterface

// File: sv/rse_cfg_if.sv
`timescale 1ns / 1ps

// Mode register write channel.
interface rse_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] ecc_mode;

	modport source (output valid, output ecc_mode, input ready);
	modport sink (input valid, input ecc_mode, output ready);
endinterface

// File: sv/rse_lfsr.sv
`timescale 1ns / 1ps

module rse_lfsr import rse_pkg::*; #(
	parameter int MAX_PARITY_WORDS = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rse_in_if.sink                            data,
	rse_cfg_if.sink                           cfg,
	input  logic                              shift_free,
	output rse_load_t                         load,
	output logic [MAX_PARITY_WORDS-1:0][7:0]  rem_next
);

	localparam int CW = $clog2(MAX_PARITY_WORDS + 1);

	logic [1:0]                           mode_q;
	logic [MAX_PARITY_WORDS-1:0][7:0]     rem_q;
	logic                                 valid_s1;
	logic [7:0]                           data_s1;
	logic                                 last_s1;
	logic                                 stall;
	logic [7:0]                           fb;
	logic [CW-1:0]                        n_cur;
	logic [4:0]                           n_nom;

	// The mode register takes every write beat.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_P10;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= cfg.ecc_mode;
		end
	end

	// A final byte waits in the input register until the shifter can take its parity.
	assign stall      = valid_s1 && last_s1 && !shift_free;
	assign data.ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			data_s1 <= data.data_byte;
			last_s1 <= data.last_data;
		end
	end

	// Active parity count, saturated at the chain length.
	assign n_nom = rse_count(mode_q);
	assign n_cur = (int'(n_nom) > MAX_PARITY_WORDS) ? CW'(MAX_PARITY_WORDS) : CW'(n_nom);

	assign fb = data_s1 ^ rem_q[0];

	// One division step: each active position takes its upper neighbor plus a
	// constant multiple of the feedback; positions past the count hold.
	for (genvar i = 0; i < MAX_PARITY_WORDS; i++) begin : g_pos
		localparam logic [7:0] C10 = rse_coef(MODE_P10, i + 1);
		localparam logic [7:0] C16 = rse_coef(MODE_P16, i + 1);
		localparam logic [7:0] C26 = rse_coef(MODE_P26, i + 1);

		logic [7:0] prod;
		logic [7:0] upper;

		always_comb begin
			case (mode_q)
				MODE_P10: prod = gf_mul(fb, C10);
				MODE_P16: prod = gf_mul(fb, C16);
				default:  prod = gf_mul(fb, C26);
			endcase
		end

		if (i < MAX_PARITY_WORDS - 1) begin : g_up
			assign upper = (CW'(i + 1) < n_cur) ? rem_q[i + 1] : 8'h00;
		end else begin : g_top
			assign upper = 8'h00;
		end

		assign rem_next[i] = (CW'(i) < n_cur) ? (upper ^ prod) : rem_q[i];
	end

	// The remainder advances on each processed byte and clears after a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (valid_s1 && !stall) begin
			rem_q <= last_s1 ? '0 : rem_next;
		end
	end

	assign load.load = valid_s1 && last_s1 && !stall;
	assign load.mode = mode_q;

endmodule

// File: sv/rse_out.sv
`timescale 1ns / 1ps

module rse_out import rse_pkg::*; #(
	parameter int MAX_PARITY_WORDS = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rse_load_t                         load,
	input  logic [MAX_PARITY_WORDS-1:0][7:0]  rem_next,
	output logic                              shift_free,
	rse_out_if.source                         ecc
);

	localparam int CW = $clog2(MAX_PARITY_WORDS + 1);

	logic [MAX_PARITY_WORDS-1:0][7:0] sh_q;
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    n_load;
	logic [4:0]                       n_nom;
	logic                             pop;

	assign n_nom  = rse_count(load.mode);
	assign n_load = (int'(n_nom) > MAX_PARITY_WORDS) ? CW'(MAX_PARITY_WORDS) : CW'(n_nom);

	// Head of the shifter is the current parity beat.
	assign ecc.valid    = (cnt_q != '0);
	assign ecc.ecc_byte = sh_q[0];
	assign ecc.last_ecc = (cnt_q == CW'(1));

	assign pop        = ecc.valid && ecc.ready;
	assign shift_free = (cnt_q == '0) || (cnt_q == CW'(1) && ecc.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load.load) begin
			cnt_q <= n_load;
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// A new block replaces the shifter contents; otherwise shift one byte per beat.
	always_ff @(posedge clk) begin
		if (load.load) begin
			sh_q <= rem_next;
		end else if (pop) begin
			for (int i = 0; i < MAX_PARITY_WORDS - 1; i++) begin
				sh_q[i] <= sh_q[i + 1];
			end
		end
	end

endmodule

// File: sv/reed_solomon_ecc_encoder_top.sv
// Systematic Reed-Solomon parity encoder for QR codes over GF(256), polynomial 0x11D.
// Data bytes enter on data, one per beat, and the beat with last_data set closes a
// block; its 10, 16 or 26 parity bytes (set by ecc_mode, code 3 acting as 26, and
// capped at MAX_PARITY_WORDS) then leave on ecc highest order first, one per beat,
// with last_ecc on the final one. The block takes one data byte per cycle: each byte
// passes an input register and a remainder update of constant field multipliers.
// Parity bytes drain from a shift register that runs alongside the next block's data,
// so a new block streams in while the previous parity leaves; only a closing byte
// arriving before that drain reaches its final beat waits. The user must write the
// mode register on cfg only while no data or parity beat is in flight; the block does
// not enforce it. A write between two bytes of an open block acts from the next byte.
`timescale 1ns / 1ps

module reed_solomon_ecc_encoder_top import rse_pkg::*; #(
	parameter int MAX_PARITY_WORDS = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	rse_in_if.sink     data,
	rse_out_if.source  ecc,
	rse_cfg_if.sink    cfg
);

	rse_load_t                        load;
	logic [MAX_PARITY_WORDS-1:0][7:0] rem_next;
	logic                             shift_free;

	// Input register, mode register and remainder chain.
	rse_lfsr #(
		.MAX_PARITY_WORDS(MAX_PARITY_WORDS)
	) u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.data      (data),
		.cfg       (cfg),
		.shift_free(shift_free),
		.load      (load),
		.rem_next  (rem_next)
	);

	// Parity output shifter.
	rse_out #(
		.MAX_PARITY_WORDS(MAX_PARITY_WORDS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.rem_next  (rem_next),
		.shift_free(shift_free),
		.ecc       (ecc)
	);

endmodule

// File: sv/rse_checker.sv
`timescale 1ns / 1ps
`include "reed_solomon_ecc_encoder_top_assert.svh"

module rse_checker import rse_pkg::*; #(
	parameter int MAX_PARITY_WORDS = 26
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [1:0] cfg_mode
);

	localparam int CW = $clog2(MAX_PARITY_WORDS + 1);

	logic [1:0]    mode_q;
	logic [2:0]    pend_q;
	logic [CW-1:0] beat_q;
	logic [CW-1:0] n_exp;
	logic [4:0]    n_nom;
	logic          in_end;
	logic          out_acc;
	logic          out_end;

	assign in_end  = in_valid && in_ready && in_last;
	assign out_acc = out_valid && out_ready;
	assign out_end = out_acc && out_last;

	assign n_nom = rse_count(mode_q);
	assign n_exp = (int'(n_nom) > MAX_PARITY_WORDS) ? CW'(MAX_PARITY_WORDS) : CW'(n_nom);

	// Shadow of the mode, closed blocks still owed parity, and beats in this block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_P10;
			pend_q <= '0;
			beat_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_mode;
			end
			if (in_end && !out_end) begin
				pend_q <= pend_q + 3'd1;
			end else if (!in_end && out_end) begin
				pend_q <= pend_q - 3'd1;
			end
			if (out_end) begin
				beat_q <= '0;
			end else if (out_acc) begin
				beat_q <= beat_q + CW'(1);
			end
		end
	end

	`RSE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "parity beat changed while stalled")

	`RSE_ASSERT_IMPL(a_no_extra_block, clk, arst_n, out_end, pend_q != 3'd0, "parity block without a closing data byte")

	`RSE_ASSERT_IMPL(a_block_length, clk, arst_n, out_end, (beat_q + CW'(1)) == n_exp, "parity block length does not match the mode")

	`RSE_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled with no parity pending")

endmodule

bind reed_solomon_ecc_encoder_top rse_checker #(
	.MAX_PARITY_WORDS(MAX_PARITY_WORDS)
) u_rse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (data.valid),
	.in_ready (data.ready),
	.in_last  (data.last_data),
	.out_valid(ecc.valid),
	.out_ready(ecc.ready),
	.out_byte (ecc.ecc_byte),
	.out_last (ecc.last_ecc),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.cfg_mode (cfg.ecc_mode)
);
